FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the command queue RTL.
// Included by every module that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must never be true while out of reset.
`define PCTQ_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define PCTQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define PCTQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/pctq_pkg.sv
// Package of the per-target coalescing command queue.
// Holds the channel structs, codes, state enum and controller/datapath links.
`timescale 1ns / 1ps

package pctq_pkg;

  localparam int MAX_TARGETS_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF  = 8;
  localparam int KEY_BITS_DEF     = 64;
  localparam int PAYLOAD_BITS_DEF = 64;

  localparam logic [3:0] CFG_A_RST = 4'd1;
  localparam logic [3:0] CFG_B_RST = 4'd2;

  localparam logic CFG_IDX_A = 1'b0;
  localparam logic CFG_IDX_B = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] target_key;
    logic [3:0]  cmd_type;
    logic [63:0] payload;
    logic [31:0] life_ms;
    logic [47:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  out_type;
    logic [63:0] out_payload;
    logic [31:0] out_timeout;
    logic [47:0] out_enqueue_time;
    logic [3:0]  queue_count;
    logic [6:0]  dropped_count;
  } out_item_t;

  typedef enum logic [2:0] {
    ACT_PUSH   = 3'd0,
    ACT_POP    = 3'd1,
    ACT_PEEK   = 3'd2,
    ACT_DEPTH  = 3'd3,
    ACT_EXPIRE = 3'd4,
    ACT_RESET  = 3'd5
  } act_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FIND,
    ST_RESOLVE,
    ST_ALLOC,
    ST_CO_RD,
    ST_CO_CHK,
    ST_APPEND,
    ST_HEAD_RD,
    ST_HEAD_OUT,
    ST_EXP_SLOT,
    ST_EXP_CHK
  } state_t;

  typedef enum logic [1:0] {
    ADDR_HEAD,
    ADDR_OFF,
    ADDR_TAIL
  } addr_sel_t;

  typedef enum logic [2:0] {
    SOP_NONE,
    SOP_ALLOC,
    SOP_INC,
    SOP_POP,
    SOP_FREE,
    SOP_CLEAR
  } slot_op_t;

  typedef enum logic [2:0] {
    RES_FAIL,
    RES_OK,
    RES_ENTRY,
    RES_COUNT,
    RES_DROP
  } res_sel_t;

  typedef struct packed {
    logic      load;
    logic      scan;
    logic      tgt_free;
    logic      tgt_inc;
    logic      off_inc;
    logic      ram_rd;
    logic      ram_wr;
    addr_sel_t addr_sel;
    slot_op_t  slot_op;
    logic      drop_inc;
    logic      fin;
    res_sel_t  res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       key_zero;
    logic       hit;
    logic       last;
    logic       found;
    logic       freef;
    logic       used;
    logic       cnt_zero;
    logic       cnt_full;
    logic       off_lt_cnt;
    logic       coal;
    logic       type_eq;
    logic       expired;
  } dp_sts_t;

endpackage

FILE: rtl/core/pctq_ram.sv
// Generic single-port-write, registered-read RAM.
// Standalone; used for the command entry store.
`timescale 1ns / 1ps

module pctq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                      wr_data,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/pctq_ctrl.sv
// Controller state machine of the command queue.
// Depends on pctq_pkg and assert_macros.svh; drives the datapath by commands.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pctq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pctq_pkg::dp_sts_t sts,
  output pctq_pkg::dp_cmd_t cmd
);

  pctq_pkg::state_t state_r;
  pctq_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pctq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != pctq_pkg::ST_IDLE);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pctq_pkg::ST_IDLE: begin
        if (start) state_nxt = pctq_pkg::ST_DISPATCH;
      end
      pctq_pkg::ST_DISPATCH: begin
        case (pctq_pkg::act_t'(sts.act))
          pctq_pkg::ACT_PUSH, pctq_pkg::ACT_POP, pctq_pkg::ACT_PEEK,
          pctq_pkg::ACT_DEPTH: begin
            state_nxt = sts.key_zero ? pctq_pkg::ST_IDLE : pctq_pkg::ST_FIND;
          end
          pctq_pkg::ACT_EXPIRE: state_nxt = pctq_pkg::ST_EXP_SLOT;
          default:              state_nxt = pctq_pkg::ST_IDLE;
        endcase
      end
      pctq_pkg::ST_FIND: begin
        if (sts.hit || sts.last) state_nxt = pctq_pkg::ST_RESOLVE;
      end
      pctq_pkg::ST_RESOLVE: begin
        state_nxt = pctq_pkg::ST_IDLE;
        case (pctq_pkg::act_t'(sts.act))
          pctq_pkg::ACT_PUSH: begin
            if (sts.found) begin
              state_nxt = sts.coal ? pctq_pkg::ST_CO_RD : pctq_pkg::ST_APPEND;
            end else if (sts.freef) begin
              state_nxt = pctq_pkg::ST_ALLOC;
            end
          end
          pctq_pkg::ACT_POP, pctq_pkg::ACT_PEEK: begin
            if (sts.found && !sts.cnt_zero) state_nxt = pctq_pkg::ST_HEAD_RD;
          end
          default: state_nxt = pctq_pkg::ST_IDLE;
        endcase
      end
      pctq_pkg::ST_ALLOC: begin
        state_nxt = sts.coal ? pctq_pkg::ST_CO_RD : pctq_pkg::ST_APPEND;
      end
      pctq_pkg::ST_CO_RD: begin
        state_nxt = sts.off_lt_cnt ? pctq_pkg::ST_CO_CHK : pctq_pkg::ST_APPEND;
      end
      pctq_pkg::ST_CO_CHK: begin
        state_nxt = sts.type_eq ? pctq_pkg::ST_IDLE : pctq_pkg::ST_CO_RD;
      end
      pctq_pkg::ST_APPEND:   state_nxt = pctq_pkg::ST_IDLE;
      pctq_pkg::ST_HEAD_RD:  state_nxt = pctq_pkg::ST_HEAD_OUT;
      pctq_pkg::ST_HEAD_OUT: state_nxt = pctq_pkg::ST_IDLE;
      pctq_pkg::ST_EXP_SLOT: begin
        if (sts.used && !sts.cnt_zero) begin
          state_nxt = pctq_pkg::ST_EXP_CHK;
        end else if (sts.last) begin
          state_nxt = pctq_pkg::ST_IDLE;
        end
      end
      pctq_pkg::ST_EXP_CHK: begin
        if (!sts.expired && sts.last) begin
          state_nxt = pctq_pkg::ST_IDLE;
        end else begin
          state_nxt = pctq_pkg::ST_EXP_SLOT;
        end
      end
      default: state_nxt = pctq_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd = '0;
    case (state_r)
      pctq_pkg::ST_IDLE: begin
        cmd.load = start;
      end
      pctq_pkg::ST_DISPATCH: begin
        case (pctq_pkg::act_t'(sts.act))
          pctq_pkg::ACT_PUSH, pctq_pkg::ACT_POP, pctq_pkg::ACT_PEEK,
          pctq_pkg::ACT_DEPTH: begin
            if (sts.key_zero) begin
              cmd.fin     = 1'b1;
              cmd.res_sel = pctq_pkg::RES_FAIL;
            end
          end
          pctq_pkg::ACT_EXPIRE: ;
          pctq_pkg::ACT_RESET: begin
            cmd.slot_op = pctq_pkg::SOP_CLEAR;
            cmd.fin     = 1'b1;
            cmd.res_sel = pctq_pkg::RES_OK;
          end
          default: begin
            cmd.fin     = 1'b1;
            cmd.res_sel = pctq_pkg::RES_FAIL;
          end
        endcase
      end
      pctq_pkg::ST_FIND: begin
        cmd.scan = 1'b1;
      end
      pctq_pkg::ST_RESOLVE: begin
        cmd.res_sel = pctq_pkg::RES_FAIL;
        case (pctq_pkg::act_t'(sts.act))
          pctq_pkg::ACT_PUSH: begin
            if (sts.found) begin
              cmd.fin = 1'b0;
            end else if (sts.freef) begin
              cmd.tgt_free = 1'b1;
            end else begin
              cmd.fin = 1'b1;
            end
          end
          pctq_pkg::ACT_POP, pctq_pkg::ACT_PEEK: begin
            cmd.fin = !(sts.found && !sts.cnt_zero);
          end
          pctq_pkg::ACT_DEPTH: begin
            cmd.fin     = 1'b1;
            cmd.res_sel = sts.found ? pctq_pkg::RES_COUNT : pctq_pkg::RES_FAIL;
          end
          default: cmd.fin = 1'b1;
        endcase
      end
      pctq_pkg::ST_ALLOC: begin
        cmd.slot_op = pctq_pkg::SOP_ALLOC;
      end
      pctq_pkg::ST_CO_RD: begin
        cmd.addr_sel = pctq_pkg::ADDR_OFF;
        cmd.ram_rd   = sts.off_lt_cnt;
      end
      pctq_pkg::ST_CO_CHK: begin
        cmd.addr_sel = pctq_pkg::ADDR_OFF;
        if (sts.type_eq) begin
          cmd.ram_wr  = 1'b1;
          cmd.fin     = 1'b1;
          cmd.res_sel = pctq_pkg::RES_OK;
        end else begin
          cmd.off_inc = 1'b1;
        end
      end
      pctq_pkg::ST_APPEND: begin
        cmd.addr_sel = pctq_pkg::ADDR_TAIL;
        cmd.fin      = 1'b1;
        if (sts.cnt_full) begin
          cmd.res_sel = pctq_pkg::RES_FAIL;
        end else begin
          cmd.ram_wr  = 1'b1;
          cmd.slot_op = pctq_pkg::SOP_INC;
          cmd.res_sel = pctq_pkg::RES_OK;
        end
      end
      pctq_pkg::ST_HEAD_RD: begin
        cmd.addr_sel = pctq_pkg::ADDR_HEAD;
        cmd.ram_rd   = 1'b1;
      end
      pctq_pkg::ST_HEAD_OUT: begin
        cmd.fin     = 1'b1;
        cmd.res_sel = pctq_pkg::RES_ENTRY;
        if (pctq_pkg::act_t'(sts.act) == pctq_pkg::ACT_POP) begin
          cmd.slot_op = pctq_pkg::SOP_POP;
        end
      end
      pctq_pkg::ST_EXP_SLOT: begin
        cmd.addr_sel = pctq_pkg::ADDR_HEAD;
        cmd.res_sel  = pctq_pkg::RES_DROP;
        if (sts.used && !sts.cnt_zero) begin
          cmd.ram_rd = 1'b1;
        end else begin
          if (sts.used) cmd.slot_op = pctq_pkg::SOP_FREE;
          if (sts.last) cmd.fin = 1'b1;
          else          cmd.tgt_inc = 1'b1;
        end
      end
      pctq_pkg::ST_EXP_CHK: begin
        cmd.res_sel = pctq_pkg::RES_DROP;
        if (sts.expired) begin
          cmd.slot_op  = pctq_pkg::SOP_POP;
          cmd.drop_inc = 1'b1;
        end else if (sts.last) begin
          cmd.fin = 1'b1;
        end else begin
          cmd.tgt_inc = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  `PCTQ_ASSERT_NEVER(a_rd_wr_excl, clk, rst_n, cmd.ram_rd && cmd.ram_wr, "RAM read and write together")
  `PCTQ_ASSERT_NEXT(a_fin_to_idle, clk, rst_n, cmd.fin, state_r == pctq_pkg::ST_IDLE, "no idle after finish")
  `PCTQ_ASSERT_IMP(a_load_idle, clk, rst_n, cmd.load, state_r == pctq_pkg::ST_IDLE, "load while busy")

endmodule

FILE: rtl/core/pctq_dp.sv
// Datapath of the command queue: request latch, slot table, entry store, result.
// Depends on pctq_pkg, pctq_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pctq_dp #(
  parameter int MAX_TARGETS  = pctq_pkg::MAX_TARGETS_DEF,
  parameter int QUEUE_DEPTH  = pctq_pkg::QUEUE_DEPTH_DEF,
  parameter int KEY_BITS     = pctq_pkg::KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = pctq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pctq_pkg::in_item_t  in_item,
  input  logic                cfg_valid,
  input  logic                cfg_index,
  input  logic [3:0]          cfg_data,
  input  pctq_pkg::dp_cmd_t   cmd,
  output pctq_pkg::dp_sts_t   sts,
  output logic                out_valid,
  output pctq_pkg::out_item_t out_item
);

  localparam int SLW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int RSW = QIW + 1;
  localparam int NE  = MAX_TARGETS * QUEUE_DEPTH;
  localparam int AW  = (NE > 1) ? $clog2(NE) : 1;
  localparam int DW  = $clog2(NE + 1);
  localparam int EW  = 4 + PAYLOAD_BITS + 32 + 48;

  // Latched request.
  logic [2:0]              act_r;
  logic [KEY_BITS-1:0]     key_r;
  logic [3:0]              type_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [31:0]             tmo_r;
  logic [47:0]             now_r;

  logic [3:0] cfg_a_r;
  logic [3:0] cfg_b_r;

  // Slot table.
  logic [KEY_BITS-1:0] slot_key_r  [MAX_TARGETS];
  logic                slot_used_r [MAX_TARGETS];
  logic [QIW-1:0]      slot_head_r [MAX_TARGETS];
  logic [CW-1:0]       slot_cnt_r  [MAX_TARGETS];

  logic [SLW-1:0] tgt_r;
  logic [SLW-1:0] free_idx_r;
  logic           found_r;
  logic           freef_r;
  logic [CW-1:0]  off_r;
  logic [DW-1:0]  drop_r;

  logic                out_valid_r;
  pctq_pkg::out_item_t out_item_r;
  pctq_pkg::out_item_t res_nxt;

  logic                cur_used;
  logic [KEY_BITS-1:0] cur_key;
  logic [QIW-1:0]      cur_head;
  logic [CW-1:0]       cur_cnt;
  logic [CW-1:0]       off_sel;
  logic [RSW-1:0]      ring_sum;
  logic [RSW-1:0]      ring_pos;
  logic [RSW-1:0]      head_sum;
  logic [QIW-1:0]      head_nxt;
  logic [AW-1:0]       ent_addr;
  logic [EW-1:0]       wr_data;
  logic [EW-1:0]       rd_data;
  logic [3:0]          rd_type;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic [31:0]         rd_tmo;
  logic [47:0]         rd_time;
  logic [48:0]         deadline;
  logic                last;
  logic                hit;

  assign cur_used = slot_used_r[tgt_r];
  assign cur_key  = slot_key_r[tgt_r];
  assign cur_head = slot_head_r[tgt_r];
  assign cur_cnt  = slot_cnt_r[tgt_r];
  assign last     = (tgt_r == SLW'(MAX_TARGETS - 1));
  assign hit      = cur_used && (cur_key == key_r);

  always_comb begin
    case (cmd.addr_sel)
      pctq_pkg::ADDR_OFF:  off_sel = off_r;
      pctq_pkg::ADDR_TAIL: off_sel = cur_cnt;
      default:             off_sel = '0;
    endcase
  end

  // Ring position: head plus offset stays below twice the depth.
  assign ring_sum = RSW'(cur_head) + RSW'(off_sel);
  assign ring_pos = (ring_sum >= RSW'(QUEUE_DEPTH)) ? ring_sum - RSW'(QUEUE_DEPTH) : ring_sum;
  assign ent_addr = AW'(tgt_r) * AW'(QUEUE_DEPTH) + AW'(ring_pos[QIW-1:0]);

  assign head_sum = RSW'(cur_head) + RSW'(1);
  assign head_nxt = (head_sum == RSW'(QUEUE_DEPTH)) ? '0 : head_sum[QIW-1:0];

  assign wr_data = {type_r, pay_r, tmo_r, now_r};
  assign rd_type = rd_data[EW-1 -: 4];
  assign rd_pay  = rd_data[PAYLOAD_BITS+79 -: PAYLOAD_BITS];
  assign rd_tmo  = rd_data[79:48];
  assign rd_time = rd_data[47:0];

  assign deadline = {1'b0, rd_time} + {17'b0, rd_tmo};

  pctq_ram #(
    .WIDTH (EW),
    .DEPTH (NE)
  ) u_entries (
    .clk     (clk),
    .wr_en   (cmd.ram_wr),
    .rd_en   (cmd.ram_rd),
    .addr    (ent_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  always_comb begin
    sts.act        = act_r;
    sts.key_zero   = (key_r == '0);
    sts.hit        = hit;
    sts.last       = last;
    sts.found      = found_r;
    sts.freef      = freef_r;
    sts.used       = cur_used;
    sts.cnt_zero   = (cur_cnt == '0);
    sts.cnt_full   = (cur_cnt == CW'(QUEUE_DEPTH));
    sts.off_lt_cnt = (off_r < cur_cnt);
    sts.coal       = (type_r == cfg_a_r) || (type_r == cfg_b_r);
    sts.type_eq    = (rd_type == type_r);
    sts.expired    = (rd_tmo != '0) && (deadline <= {1'b0, now_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_item.action;
      key_r  <= in_item.target_key[KEY_BITS-1:0];
      type_r <= in_item.cmd_type;
      pay_r  <= in_item.payload[PAYLOAD_BITS-1:0];
      tmo_r  <= in_item.life_ms;
      now_r  <= in_item.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_a_r <= pctq_pkg::CFG_A_RST;
      cfg_b_r <= pctq_pkg::CFG_B_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        pctq_pkg::CFG_IDX_A: cfg_a_r <= cfg_data;
        pctq_pkg::CFG_IDX_B: cfg_b_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.slot_op == pctq_pkg::SOP_ALLOC) begin
      slot_key_r[tgt_r] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TARGETS; i++) begin
        slot_used_r[i] <= 1'b0;
        slot_head_r[i] <= '0;
        slot_cnt_r[i]  <= '0;
      end
    end else begin
      case (cmd.slot_op)
        pctq_pkg::SOP_ALLOC: begin
          slot_used_r[tgt_r] <= 1'b1;
          slot_head_r[tgt_r] <= '0;
          slot_cnt_r[tgt_r]  <= '0;
        end
        pctq_pkg::SOP_INC: begin
          slot_cnt_r[tgt_r] <= cur_cnt + CW'(1);
        end
        pctq_pkg::SOP_POP: begin
          // Taking the last entry frees the slot.
          if (cur_cnt == CW'(1)) begin
            slot_used_r[tgt_r] <= 1'b0;
            slot_head_r[tgt_r] <= '0;
          end else begin
            slot_head_r[tgt_r] <= head_nxt;
          end
          slot_cnt_r[tgt_r] <= cur_cnt - CW'(1);
        end
        pctq_pkg::SOP_FREE: begin
          slot_used_r[tgt_r] <= 1'b0;
          slot_head_r[tgt_r] <= '0;
          slot_cnt_r[tgt_r]  <= '0;
        end
        pctq_pkg::SOP_CLEAR: begin
          for (int i = 0; i < MAX_TARGETS; i++) begin
            slot_used_r[i] <= 1'b0;
            slot_head_r[i] <= '0;
            slot_cnt_r[i]  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r      <= '0;
      free_idx_r <= '0;
      found_r    <= 1'b0;
      freef_r    <= 1'b0;
      off_r      <= '0;
      drop_r     <= '0;
    end else if (cmd.load) begin
      tgt_r   <= '0;
      found_r <= 1'b0;
      freef_r <= 1'b0;
      off_r   <= '0;
      drop_r  <= '0;
    end else begin
      if (cmd.scan) begin
        if (hit) begin
          found_r <= 1'b1;
        end else begin
          if (!cur_used && !freef_r) begin
            freef_r    <= 1'b1;
            free_idx_r <= tgt_r;
          end
          if (!last) tgt_r <= tgt_r + SLW'(1);
        end
      end
      if (cmd.tgt_free) tgt_r  <= free_idx_r;
      if (cmd.tgt_inc)  tgt_r  <= tgt_r + SLW'(1);
      if (cmd.off_inc)  off_r  <= off_r + CW'(1);
      if (cmd.drop_inc) drop_r <= drop_r + DW'(1);
    end
  end

  always_comb begin
    res_nxt = '0;
    case (cmd.res_sel)
      pctq_pkg::RES_OK: res_nxt.status = pctq_pkg::STATUS_OK;
      pctq_pkg::RES_ENTRY: begin
        res_nxt.status           = pctq_pkg::STATUS_OK;
        res_nxt.out_type         = rd_type;
        res_nxt.out_payload      = 64'(rd_pay);
        res_nxt.out_timeout      = rd_tmo;
        res_nxt.out_enqueue_time = rd_time;
      end
      pctq_pkg::RES_COUNT: begin
        res_nxt.status      = pctq_pkg::STATUS_OK;
        res_nxt.queue_count = (32'(cur_cnt) > 32'd15) ? 4'd15 : 4'(cur_cnt);
      end
      pctq_pkg::RES_DROP: begin
        res_nxt.status        = pctq_pkg::STATUS_OK;
        res_nxt.dropped_count = (32'(drop_r) > 32'd127) ? 7'd127 : 7'(drop_r);
      end
      default: res_nxt.status = pctq_pkg::STATUS_FAIL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) out_item_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `PCTQ_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, slot_cnt_r[tgt_r] <= CW'(QUEUE_DEPTH), "count above depth")
  `PCTQ_ASSERT_IMP(a_free_empty, clk, rst_n, !slot_used_r[tgt_r], slot_cnt_r[tgt_r] == '0, "free slot holds entries")
  `PCTQ_ASSERT_IMP(a_out_after_fin, clk, rst_n, out_valid_r, $past(cmd.fin), "result without finish")

endmodule

FILE: rtl/core/per_target_coalescing_command_queue.sv
// Top level of the per-target coalescing command queue.
// Depends on pctq_pkg, pctq_ctrl, pctq_dp and pctq_ram.
`timescale 1ns / 1ps

// Usage. A command is transferred on in_item at a rising edge where start is high
// and busy is low. Configuration writes use cfg_valid, cfg_index and cfg_data; the
// port is always ready, and writes belong in idle periods. Index 0 is the first
// coalescing type code and index 1 the second.
// Each command gives exactly one result, shown on out_item for one cycle with
// out_valid high. The receiver cannot stall; the result must be taken then.
// The controller walks the slot table one slot per cycle while searching for the key
// and reads the entry RAM with one registered read per step. The block handles one
// command at a time; busy falls in the cycle the result is shown, so the next
// command can be transferred then.
// Reset clears all slots and restores the coalescing codes to 1 and 2. Entry RAM
// contents are not cleared; only entries written since are ever read.
module per_target_coalescing_command_queue #(
  parameter int MAX_TARGETS  = pctq_pkg::MAX_TARGETS_DEF,
  parameter int QUEUE_DEPTH  = pctq_pkg::QUEUE_DEPTH_DEF,
  parameter int KEY_BITS     = pctq_pkg::KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = pctq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pctq_pkg::in_item_t  in_item,
  output logic                out_valid,
  output pctq_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [3:0]          cfg_data
);

  pctq_pkg::dp_cmd_t cmd;
  pctq_pkg::dp_sts_t sts;

  // Configuration registers take a write in any cycle.
  assign cfg_ready = 1'b1;

  pctq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  pctq_dp #(
    .MAX_TARGETS  (MAX_TARGETS),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
